@@ design/olle_pkg.sv @@
// Package for the ordered linked list engine: sizes, command and status codes,
// request and result structs, word conversion functions. No dependencies.
package olle_pkg;
    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY + 1);
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(CAPACITY);

    localparam logic [3:0] CMD_INS_REAR   = 4'd0;
    localparam logic [3:0] CMD_DEL_FRONT  = 4'd1;
    localparam logic [3:0] CMD_INS_FRONT  = 4'd2;
    localparam logic [3:0] CMD_DEL_REAR   = 4'd3;
    localparam logic [3:0] CMD_READ_ALL   = 4'd4;
    localparam logic [3:0] CMD_INS_BEFORE = 4'd5;
    localparam logic [3:0] CMD_INS_AFTER  = 4'd6;
    localparam logic [3:0] CMD_DEL_KEY    = 4'd7;
    localparam logic [3:0] CMD_CLEAR      = 4'd8;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] match_key;
        logic signed [31:0] new_value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               last_of_run;
        logic [5:0]         length;
    } t_rsp;

    // Narrow a 32-bit input to a stored word.
    function automatic logic [DATA_WIDTH-1:0] narrow(input logic [31:0] x);
        logic [63:0] s;
        s = {{32{x[31]}}, x};
        return s[DATA_WIDTH-1:0];
    endfunction

    // Widen a stored word to the 32-bit result field.
    function automatic logic [31:0] widen(input logic [DATA_WIDTH-1:0] x);
        logic [63:0] s;
        s = {{(64-DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
        return s[31:0];
    endfunction
endpackage

@@ design/olle_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module olle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/olle_free_map.sv @@
// Free-slot map with lowest-free-slot search and element count.
// Depends on olle_pkg.
module olle_free_map
    import olle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_take,
    input  logic              i_give,
    input  logic [SLOT_W-1:0] i_slot,
    output logic [IDX_W-1:0]  o_free_slot,
    output logic [IDX_W-1:0]  o_count
);
    logic [CAPACITY-1:0] r_free;
    logic [IDX_W-1:0]    r_count;

    // Priority search for the lowest free slot.
    always_comb begin
        o_free_slot = NULL_IDX;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                o_free_slot = IDX_W'(i);
            end
        end
    end

    assign o_count = r_count;

    // Map and count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_free  <= '1;
            r_count <= '0;
        end else if (i_take) begin
            r_free[i_slot] <= 1'b0;
            r_count        <= r_count + 1'b1;
        end else if (i_give) begin
            r_free[i_slot] <= 1'b1;
            r_count        <= r_count - 1'b1;
        end
    end

    ap_take_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_free[i_slot]) else $error("take of a used slot");
    ap_give_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_give |-> !r_free[i_slot]) else $error("give of a free slot");
    ap_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IDX_W'(CAPACITY)) else $error("count overflow");
endmodule

@@ design/ordered_linked_list_engine.sv @@
// Ordered linked list engine: values and links in two RAMs with registered read data.
// Inserts at either end, clear and empty-list cases answer from the first decision
// step (S_OUT); walks read each link in S_RD and check it in S_CHK, up to CAPACITY links.
// One request in work at a time; read all gives one result per link, and a held
// result stalls the sequencer.
// Synchronous active-low reset empties the list at once; RAMs need no clearing.
// Depends on olle_pkg, olle_ram, olle_free_map.
module ordered_linked_list_engine
    import olle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]            r_state;
    logic [3:0]            r_cmd;
    logic [DATA_WIDTH-1:0] r_key, r_val;
    logic [IDX_W-1:0]      r_head, r_tail, r_cur, r_prev;
    logic [IDX_W-1:0]      r_steps;
    logic                  r_ovalid;
    t_rsp                  r_rsp;

    // RAM ports.
    logic                  val_we, lnk_we;
    logic [SLOT_W-1:0]     val_wa, lnk_wa, rd_a;
    logic [DATA_WIDTH-1:0] val_wd, val_rd;
    logic [IDX_W-1:0]      lnk_wd, lnk_rd;

    logic [IDX_W-1:0] free_slot, count;
    logic             fm_clear, fm_take, fm_give;
    logic [SLOT_W-1:0] fm_slot;

    olle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
        .i_clk, .i_we(val_we), .i_waddr(val_wa), .i_wdata(val_wd),
        .i_raddr(rd_a), .o_rdata(val_rd));
    olle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_lnk (
        .i_clk, .i_we(lnk_we), .i_waddr(lnk_wa), .i_wdata(lnk_wd),
        .i_raddr(rd_a), .o_rdata(lnk_rd));
    olle_free_map u_fm (
        .i_clk, .i_rst_n, .i_clear(fm_clear), .i_take(fm_take), .i_give(fm_give),
        .i_slot(fm_slot), .o_free_slot(free_slot), .o_count(count));

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;
    assign rd_a    = r_cur[SLOT_W-1:0];

    logic acc, out_free;
    assign acc      = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    logic cur_null, nxt_null, hit, full;
    assign cur_null = (r_cur >= NULL_IDX);
    assign nxt_null = (lnk_rd >= NULL_IDX);
    assign hit      = (val_rd == r_key);
    assign full     = (free_slot >= NULL_IDX);

    // Second write of a two-link update, done in S_WR.
    logic [IDX_W-1:0] r_slot, r_tail_old, r_prev_old;

    logic [2:0]       n_state;
    logic [IDX_W-1:0] n_head, n_tail, n_cur, n_prev, n_steps, n_len;
    logic             emit, emit_last;
    logic [1:0]       emit_st;
    logic [DATA_WIDTH-1:0] emit_el;

    // Command sequencer.
    always_comb begin
        n_state = r_state; n_head = r_head; n_tail = r_tail;
        n_cur = r_cur; n_prev = r_prev; n_steps = r_steps;
        val_we = 1'b0; lnk_we = 1'b0; val_wa = free_slot[SLOT_W-1:0];
        lnk_wa = free_slot[SLOT_W-1:0]; val_wd = r_val; lnk_wd = NULL_IDX;
        fm_clear = 1'b0; fm_take = 1'b0; fm_give = 1'b0; fm_slot = free_slot[SLOT_W-1:0];
        emit = 1'b0; emit_last = 1'b1; emit_st = ST_DONE; emit_el = '0;
        n_len = count;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_cur = r_head; n_prev = NULL_IDX; n_steps = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // First decision step after acceptance.
                if (out_free) begin
                    priority if (r_cmd == CMD_INS_REAR || r_cmd == CMD_INS_FRONT) begin
                        emit = 1'b1;
                        if (full) begin
                            emit_st = ST_FULL; n_state = S_IDLE;
                        end else begin
                            fm_take = 1'b1; val_we = 1'b1; lnk_we = 1'b1;
                            n_len = count + 1'b1;
                            if (r_cmd == CMD_INS_REAR) begin
                                lnk_wd = NULL_IDX;
                                if (r_head >= NULL_IDX) n_head = free_slot;
                                n_tail = free_slot;
                                n_state = (r_tail < NULL_IDX && r_head < NULL_IDX)
                                          ? S_WR : S_IDLE;
                            end else begin
                                lnk_wd = r_head; n_head = free_slot;
                                if (r_tail >= NULL_IDX) n_tail = free_slot;
                                n_state = S_IDLE;
                            end
                        end
                    end else if (r_cmd == CMD_CLEAR) begin
                        emit = 1'b1; fm_clear = 1'b1; n_len = '0;
                        n_head = NULL_IDX; n_tail = NULL_IDX; n_state = S_IDLE;
                    end else if (r_cmd == CMD_DEL_FRONT || r_cmd == CMD_DEL_REAR ||
                                 r_cmd == CMD_READ_ALL || r_cmd == CMD_INS_BEFORE ||
                                 r_cmd == CMD_INS_AFTER || r_cmd == CMD_DEL_KEY) begin
                        if (r_head >= NULL_IDX) begin
                            emit = 1'b1; emit_st = ST_EMPTY; n_state = S_IDLE;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        emit = 1'b1; n_state = S_IDLE;
                    end
                end
            end
            S_RD: begin
                // RAM read of r_cur in flight.
                n_state = S_CHK;
            end
            S_CHK: begin
                if (out_free) begin
                    n_state = S_RD;
                    n_prev  = r_cur; n_cur = lnk_rd; n_steps = r_steps + 1'b1;
                    unique case (r_cmd)
                        CMD_DEL_FRONT: begin
                            emit = 1'b1; emit_el = val_rd; fm_give = 1'b1;
                            fm_slot = r_cur[SLOT_W-1:0]; n_len = count - 1'b1;
                            n_head = lnk_rd;
                            if (nxt_null) n_tail = NULL_IDX;
                            n_state = S_IDLE;
                        end
                        CMD_DEL_REAR: begin
                            if (nxt_null || r_steps == IDX_W'(CAPACITY - 1)) begin
                                emit = 1'b1; emit_el = val_rd; fm_give = 1'b1;
                                fm_slot = r_cur[SLOT_W-1:0]; n_len = count - 1'b1;
                                n_state = S_IDLE;
                                if (r_prev >= NULL_IDX) begin
                                    n_head = NULL_IDX; n_tail = NULL_IDX;
                                end else begin
                                    lnk_we = 1'b1; lnk_wa = r_prev[SLOT_W-1:0];
                                    lnk_wd = NULL_IDX; n_tail = r_prev;
                                end
                            end
                        end
                        CMD_READ_ALL: begin
                            emit = 1'b1; emit_el = val_rd;
                            emit_last = nxt_null || r_steps == IDX_W'(CAPACITY - 1);
                            if (emit_last) n_state = S_IDLE;
                        end
                        CMD_INS_BEFORE, CMD_INS_AFTER, CMD_DEL_KEY: begin
                            if (hit) begin
                                n_state = S_IDLE; emit = 1'b1;
                                if (r_cmd == CMD_DEL_KEY) begin
                                    emit_el = val_rd; fm_give = 1'b1;
                                    fm_slot = r_cur[SLOT_W-1:0]; n_len = count - 1'b1;
                                    if (r_prev >= NULL_IDX) n_head = lnk_rd;
                                    else begin
                                        lnk_we = 1'b1; lnk_wa = r_prev[SLOT_W-1:0];
                                        lnk_wd = lnk_rd;
                                    end
                                    if (r_tail == r_cur) n_tail = r_prev;
                                end else if (full) begin
                                    emit_st = ST_FULL;
                                end else begin
                                    fm_take = 1'b1; val_we = 1'b1; lnk_we = 1'b1;
                                    n_len = count + 1'b1;
                                    if (r_cmd == CMD_INS_BEFORE) begin
                                        lnk_wd = r_cur;
                                        if (r_prev >= NULL_IDX) n_head = free_slot;
                                        else n_state = S_WR;
                                    end else begin
                                        lnk_wd = lnk_rd;
                                        if (r_tail == r_cur) n_tail = free_slot;
                                        n_state = S_WR;
                                    end
                                end
                            end else if (nxt_null || r_steps == IDX_W'(CAPACITY - 1)) begin
                                emit = 1'b1; emit_st = ST_NOT_FOUND; n_state = S_IDLE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WR: begin
                // Link the new slot into its predecessor.
                lnk_we = 1'b1; lnk_wd = r_slot;
                unique case (r_cmd)
                    CMD_INS_REAR:   lnk_wa = r_tail_old[SLOT_W-1:0];
                    CMD_INS_BEFORE: lnk_wa = r_prev_old[SLOT_W-1:0];
                    default:        lnk_wa = r_prev_old[SLOT_W-1:0];
                endcase
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_head <= NULL_IDX; r_tail <= NULL_IDX;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_head <= n_head; r_tail <= n_tail;
            if (emit) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
        if (acc) begin
            r_cmd <= i_req.cmd; r_key <= narrow(i_req.match_key);
            r_val <= narrow(i_req.new_value);
        end
        r_cur <= n_cur; r_prev <= n_prev; r_steps <= n_steps;
        if (fm_take) begin
            r_slot <= free_slot; r_tail_old <= r_tail;
            // Insert after links the hit slot to the new slot.
            r_prev_old <= (r_cmd == CMD_INS_AFTER) ? r_cur : r_prev;
        end
        if (emit) begin
            r_rsp.status      <= emit_st;
            r_rsp.element     <= widen(emit_el);
            r_rsp.last_of_run <= emit_last;
            r_rsp.length      <= 6'(n_len);
        end
    end

    ap_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free) else $error("result overwritten");
    ap_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head >= NULL_IDX) == (r_tail >= NULL_IDX)) else $error("ends disagree");
    ap_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head >= NULL_IDX) |-> count == '0) else $error("count on empty list");
endmodule

@@ sim/tb_ordered_linked_list_engine.sv @@
// Testbench for the ordered linked list engine: directed table, a fill to capacity, then random
// command mix, all results checked against a behavioral list model.
// Depends on olle_pkg and ordered_linked_list_engine.
`timescale 1ns / 100ps

module tb_ordered_linked_list_engine
    import olle_pkg::*;
();

    localparam int N_RANDOM    = 250;
    localparam int WATCHDOG    = 20000;
    localparam int HOLD_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    ordered_linked_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // Behavioral list: plain queue of elements in list order.
    logic signed [31:0] list_q[$];
    t_rsp               rsp_expected_q[$];

    int  n_mismatch;
    int  n_results;
    int  n_requests;
    int  idle_cycles;
    bit  quiet_phase;
    bit  hold_rx;

    // Directed table row: request plus optional typed-in expectation.
    typedef struct {
        t_req req;
        bit   has_exp;
        t_rsp exp;
    } t_row;
    t_row dir_tab[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_rsp mk_rsp(logic [1:0] st, logic signed [31:0] el,
                                    logic lst);
        t_rsp r;
        r.status      = st;
        r.element     = el;
        r.last_of_run = lst;
        r.length      = 6'(list_q.size());
        return r;
    endfunction

    function automatic int find_key(logic signed [31:0] k);
        foreach (list_q[i])
            if (list_q[i] == k) return i;
        return -1;
    endfunction

    // Apply one command to the list and queue the results it produces.
    function automatic void predict_list_op(t_req rq);
        int   pos;
        logic signed [31:0] v;
        logic signed [31:0] k;
        v = widen(narrow(rq.new_value));
        k = widen(narrow(rq.match_key));
        case (rq.cmd)
            CMD_INS_REAR, CMD_INS_FRONT: begin
                if (list_q.size() >= CAPACITY) begin
                    rsp_expected_q.push_back(mk_rsp(ST_FULL, 0, 1'b1));
                end else begin
                    if (rq.cmd == CMD_INS_REAR) list_q.push_back(v);
                    else list_q.push_front(v);
                    rsp_expected_q.push_back(mk_rsp(ST_DONE, 0, 1'b1));
                end
            end
            CMD_DEL_FRONT, CMD_DEL_REAR: begin
                if (list_q.size() == 0) begin
                    rsp_expected_q.push_back(mk_rsp(ST_EMPTY, 0, 1'b1));
                end else begin
                    v = (rq.cmd == CMD_DEL_FRONT) ? list_q.pop_front() : list_q.pop_back();
                    rsp_expected_q.push_back(mk_rsp(ST_DONE, v, 1'b1));
                end
            end
            CMD_READ_ALL: begin
                if (list_q.size() == 0)
                    rsp_expected_q.push_back(mk_rsp(ST_EMPTY, 0, 1'b1));
                else
                    foreach (list_q[i])
                        rsp_expected_q.push_back(mk_rsp(ST_DONE, list_q[i],
                                                        i == list_q.size() - 1));
            end
            CMD_INS_BEFORE, CMD_INS_AFTER: begin
                pos = find_key(k);
                if (list_q.size() == 0)
                    rsp_expected_q.push_back(mk_rsp(ST_EMPTY, 0, 1'b1));
                else if (pos < 0)
                    rsp_expected_q.push_back(mk_rsp(ST_NOT_FOUND, 0, 1'b1));
                else if (list_q.size() >= CAPACITY)
                    rsp_expected_q.push_back(mk_rsp(ST_FULL, 0, 1'b1));
                else begin
                    list_q.insert(rq.cmd == CMD_INS_BEFORE ? pos : pos + 1, v);
                    rsp_expected_q.push_back(mk_rsp(ST_DONE, 0, 1'b1));
                end
            end
            CMD_DEL_KEY: begin
                pos = find_key(k);
                if (list_q.size() == 0)
                    rsp_expected_q.push_back(mk_rsp(ST_EMPTY, 0, 1'b1));
                else if (pos < 0)
                    rsp_expected_q.push_back(mk_rsp(ST_NOT_FOUND, 0, 1'b1));
                else begin
                    v = list_q[pos];
                    list_q.delete(pos);
                    rsp_expected_q.push_back(mk_rsp(ST_DONE, v, 1'b1));
                end
            end
            CMD_CLEAR: begin
                list_q.delete();
                rsp_expected_q.push_back(mk_rsp(ST_DONE, 0, 1'b1));
            end
            default: rsp_expected_q.push_back(mk_rsp(ST_DONE, 0, 1'b1));
        endcase
    endfunction

    function automatic t_req mk_req(logic [3:0] c, logic signed [31:0] k,
                                    logic signed [31:0] v);
        t_req r;
        r.cmd       = c;
        r.match_key = k;
        r.new_value = v;
        return r;
    endfunction

    function automatic void add_row(t_req rq, bit he, logic [1:0] st,
                                    logic signed [31:0] el, logic [5:0] len);
        t_row r;
        r.req     = rq;
        r.has_exp = he;
        r.exp.status      = st;
        r.exp.element     = el;
        r.exp.last_of_run = 1'b1;
        r.exp.length      = len;
        dir_tab.push_back(r);
    endfunction

    // Random value: often from a small pool so that key searches hit.
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return $signed(32'($urandom_range(0, 15)));
        endcase
    endfunction

    function automatic t_req rand_req();
        logic [3:0] c;
        int         pick;
        logic signed [31:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 22) c = CMD_INS_REAR;
        else if (pick < 36) c = CMD_INS_FRONT;
        else if (pick < 46) c = CMD_INS_BEFORE;
        else if (pick < 56) c = CMD_INS_AFTER;
        else if (pick < 66) c = CMD_DEL_KEY;
        else if (pick < 74) c = CMD_DEL_FRONT;
        else if (pick < 82) c = CMD_DEL_REAR;
        else if (pick < 93) c = CMD_READ_ALL;
        else if (pick < 96) c = CMD_CLEAR;
        else c = 4'($urandom_range(9, 15));
        // Keys mostly taken from the list so that searches succeed.
        if (list_q.size() > 0 && $urandom_range(0, 3) != 0)
            k = list_q[$urandom_range(0, list_q.size() - 1)];
        else
            k = rand_word();
        return mk_req(c, k, rand_word());
    endfunction

    // Send one request, waiting out the stall.
    task automatic send_req(t_req rq);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 1'b0;
            i_req   <= t_req'({$urandom(), $urandom(), 4'($urandom())});
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= rq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_list_op(rq);
        n_requests++;
        @(negedge i_clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off.
    initial begin
        int burst;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 14);
                i_stall <= 1'b1;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Long receiver hold-off while requests keep coming, counted here.
    initial begin
        hold_rx = 1'b0;
        @(posedge i_rst_n);
        wait (n_requests >= 60);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    // Result checking at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_rsp e;
            n_results++;
            if (rsp_expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected result %p", o_rsp);
            end else begin
                e = rsp_expected_q.pop_front();
                if (o_rsp.status !== e.status || o_rsp.element !== e.element ||
                    o_rsp.last_of_run !== e.last_of_run || o_rsp.length !== e.length) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: result %0d expected %p got %p",
                                 n_results, e, o_rsp);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || hold_rx)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("ERROR: watchdog expired");
            $display("Some tests failed");
            $finish;
        end
    end

    // Main stimulus.
    initial begin
        t_row r;
        n_mismatch  = 0;
        n_results   = 0;
        n_requests  = 0;
        idle_cycles = 0;
        quiet_phase = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty-list cases, extremes, every command.
        add_row(mk_req(CMD_READ_ALL, 0, 0), 1, ST_EMPTY, 0, 0);
        add_row(mk_req(CMD_DEL_FRONT, 0, 0), 1, ST_EMPTY, 0, 0);
        add_row(mk_req(CMD_DEL_REAR, 0, 0), 1, ST_EMPTY, 0, 0);
        add_row(mk_req(CMD_DEL_KEY, 5, 0), 1, ST_EMPTY, 0, 0);
        add_row(mk_req(CMD_INS_BEFORE, 5, 1), 1, ST_EMPTY, 0, 0);
        add_row(mk_req(CMD_INS_AFTER, 5, 1), 1, ST_EMPTY, 0, 0);
        add_row(mk_req(CMD_INS_REAR, 0, 32'sh7fffffff), 1, ST_DONE, 0, 1);
        add_row(mk_req(CMD_INS_FRONT, 0, 32'sh80000000), 1, ST_DONE, 0, 2);
        add_row(mk_req(CMD_INS_REAR, 0, -1), 1, ST_DONE, 0, 3);
        add_row(mk_req(CMD_INS_AFTER, 32'sh7fffffff, 7), 0, 0, 0, 0);
        add_row(mk_req(CMD_INS_BEFORE, 32'sh80000000, 9), 0, 0, 0, 0);
        add_row(mk_req(CMD_INS_AFTER, -1, 11), 0, 0, 0, 0);
        add_row(mk_req(CMD_DEL_KEY, 1234, 0), 1, ST_NOT_FOUND, 0, 6);
        add_row(mk_req(CMD_INS_BEFORE, 1234, 0), 1, ST_NOT_FOUND, 0, 6);
        add_row(mk_req(CMD_READ_ALL, 0, 0), 0, 0, 0, 0);
        add_row(mk_req(CMD_DEL_KEY, -1, 0), 0, 0, 0, 0);
        add_row(mk_req(CMD_DEL_FRONT, 0, 0), 0, 0, 0, 0);
        add_row(mk_req(CMD_DEL_REAR, 0, 0), 0, 0, 0, 0);
        add_row(mk_req(4'd9, 0, 0), 0, 0, 0, 0);
        add_row(mk_req(4'd15, -1, -1), 0, 0, 0, 0);
        add_row(mk_req(CMD_CLEAR, 0, 0), 1, ST_DONE, 0, 0);
        add_row(mk_req(CMD_READ_ALL, 0, 0), 1, ST_EMPTY, 0, 0);

        foreach (dir_tab[i]) begin
            r = dir_tab[i];
            send_req(r.req);
            // The typed-in expectation must agree with the list model.
            if (r.has_exp && rsp_expected_q[$] !== r.exp) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: directed row %0d expected %p, list model gives %p",
                             i, r.exp, rsp_expected_q[$]);
            end
        end

        // Fill to capacity, push past it, then read the full list and clear it.
        for (int i = 0; i < CAPACITY; i++)
            send_req(mk_req(CMD_INS_REAR, 0, $signed(32'(i))));
        send_req(mk_req(CMD_INS_FRONT, 0, 99));
        send_req(mk_req(CMD_INS_AFTER, 3, 99));
        send_req(mk_req(CMD_READ_ALL, 0, 0));
        send_req(mk_req(CMD_CLEAR, 0, 0));

        // Random part; the last stretch runs with no idling.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 50) quiet_phase = 1'b1;
            send_req(rand_req());
        end
        send_req(mk_req(CMD_READ_ALL, 0, 0));
        i_valid <= 1'b0;

        while (rsp_expected_q.size() != 0) @(posedge i_clk);
        repeat (2 * CAPACITY + 10) @(posedge i_clk);

        $display("Covered %0d requests and %0d results, list filled to %0d slots.",
                 n_requests, n_results, CAPACITY);
        if (n_mismatch == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
